@@ rtl/wildcard_star_matcher_core_defines.svh @@
// assertion helpers for the matcher core rtl
`ifndef WILDCARD_STAR_MATCHER_CORE_DEFINES_SVH
`define WILDCARD_STAR_MATCHER_CORE_DEFINES_SVH

// same-cycle implication, held off during reset
`define WSM_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off during reset
`define WSM_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/wsm_pkg.sv @@
`default_nettype none

package wsm_pkg;

	// default pattern capacity in bytes
	localparam int unsigned PATTERN_MAX_DEF = 64;

	// the only wildcard byte
	localparam logic [7:0] STAR_BYTE = 8'h2A;

	typedef enum logic [1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_APPEND = 2'd1,
		MODE_STRING = 2'd2,
		MODE_END    = 2'd3
	} mode_t;

endpackage

`default_nettype wire

@@ rtl/wsm_in_if.sv @@
`default_nettype none

interface wsm_in_if;
	import wsm_pkg::*;

	logic       valid;
	logic       ready;
	mode_t      mode;
	logic [7:0] char_code;

	modport source (output valid, output mode, output char_code, input ready);
	modport sink (input valid, input mode, input char_code, output ready);
endinterface

`default_nettype wire

@@ rtl/wsm_out_if.sv @@
`default_nettype none

interface wsm_out_if;
	logic valid;
	logic ready;
	logic matched;
	logic pattern_overflow;

	modport source (output valid, output matched, output pattern_overflow, input ready);
	modport sink (input valid, input matched, input pattern_overflow, output ready);
endinterface

`default_nettype wire

@@ rtl/wsm_closure.sv @@
`default_nettype none

// empty-star closure: a reachable position sitting on a star also reaches the
// next one; done as a log-depth segmented prefix-or
module wsm_closure #(
	parameter int unsigned N = wsm_pkg::PATTERN_MAX_DEF
) (
	input  logic [N:0]   active,
	input  logic [N-1:0] star,
	output logic [N:0]   closed
);
	localparam int unsigned LVLS = $clog2(N + 1);

	logic [N:0] g_l [LVLS+1];
	logic [N:0] p_l [LVLS+1];

	// p at position k: position k-1 holds a star
	assign g_l[0] = active;
	assign p_l[0] = {star, 1'b0};

	for (genvar d = 0; d < LVLS; d++) begin : g_lvl
		localparam int unsigned S = 1 << d;
		for (genvar k = 0; k <= N; k++) begin : g_bit
			if (k >= S) begin : g_comb
				assign g_l[d+1][k] = g_l[d][k] | (p_l[d][k] & g_l[d][k-S]);
				assign p_l[d+1][k] = p_l[d][k] & p_l[d][k-S];
			end else begin : g_pass
				assign g_l[d+1][k] = g_l[d][k];
				assign p_l[d+1][k] = p_l[d][k];
			end
		end
	end

	assign closed = g_l[LVLS];
endmodule

`default_nettype wire

@@ rtl/wildcard_star_matcher_core.sv @@
// an end-of-string item reaches its result through the input register, then the
// result register
// throughput: one item per cycle; a string byte updates every position at once
// only a stalled result register holds back an end-of-string item, and the items behind it
// reset: pattern emptied, overflow cleared, only position zero reachable;
// pattern bytes themselves are not cleared and are masked by the length
`default_nettype none

`include "wildcard_star_matcher_core_defines.svh"

module wildcard_star_matcher_core #(
	parameter int unsigned PATTERN_MAX = wsm_pkg::PATTERN_MAX_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	wsm_in_if.sink    item,
	wsm_out_if.source result
);
	import wsm_pkg::*;

	localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);
	localparam int unsigned IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PATTERN_MAX);
	localparam logic [PATTERN_MAX:0] ACT_INIT = (PATTERN_MAX + 1)'(1);

	// input register
	logic       valid_s1;
	mode_t      mode_s1;
	logic [7:0] char_s1;

	// pattern and match state
	logic [7:0]           store_q [PATTERN_MAX];
	logic [LEN_W-1:0]     len_q;
	logic [PATTERN_MAX:0] act_q;
	logic                 ovf_q;

	// result register
	logic out_valid_q;
	logic matched_q;
	logic out_ovf_q;

	// per-position decode of the stored pattern
	logic [PATTERN_MAX-1:0] star_vec;
	logic [PATTERN_MAX-1:0] hit_vec;
	logic [PATTERN_MAX:0]   closed;
	logic [PATTERN_MAX:0]   nxt;
	logic                   s1_go;
	logic                   room;

	// positions at or beyond the length never propagate
	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_pos
		logic live;
		assign live        = LEN_W'(i) < len_q;
		assign star_vec[i] = live && (store_q[i] == STAR_BYTE);
		// a star position takes the self-loop branch, never the literal one
		assign hit_vec[i]  = live && (store_q[i] != STAR_BYTE) && (store_q[i] == char_s1);
	end

	wsm_closure #(
		.N(PATTERN_MAX)
	) u_closure (
		.active(act_q),
		.star  (star_vec),
		.closed(closed)
	);

	// star keeps its own position, a literal hit moves one position on
	assign nxt = {closed[PATTERN_MAX-1:0] & hit_vec, 1'b0}
		| {1'b0, closed[PATTERN_MAX-1:0] & star_vec};

	assign room = len_q != LEN_MAX;

	// only an end-of-string item needs the result register to be free
	assign s1_go = valid_s1 && ((mode_s1 != MODE_END) || !out_valid_q || result.ready);

	// next transfer is taken while the current one leaves the input register
	assign item.ready = !valid_s1 || s1_go;

	assign result.valid            = out_valid_q;
	assign result.matched          = matched_q;
	assign result.pattern_overflow = out_ovf_q;

	// input register payload
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			mode_s1 <= item.mode;
			char_s1 <= item.char_code;
		end
	end

	// pattern bytes, written at the current length
	always_ff @(posedge clk) begin
		if (s1_go && (mode_s1 == MODE_APPEND) && room) begin
			store_q[len_q[IDX_W-1:0]] <= char_s1;
		end
	end

	// result payload: match flag is the closed vector at the pattern end
	always_ff @(posedge clk) begin
		if (s1_go && (mode_s1 == MODE_END)) begin
			matched_q <= closed[len_q];
			out_ovf_q <= ovf_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			len_q       <= '0;
			act_q       <= ACT_INIT;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (item.ready) begin
				valid_s1 <= item.valid;
			end

			if (s1_go && (mode_s1 == MODE_END)) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			if (s1_go) begin
				case (mode_s1)
					MODE_CLEAR: begin
						len_q <= '0;
						ovf_q <= 1'b0;
						act_q <= ACT_INIT;
					end
					MODE_APPEND: begin
						// reachable positions of a running string are kept
						if (room) begin
							len_q <= len_q + LEN_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
					MODE_STRING: begin
						act_q <= nxt;
					end
					MODE_END: begin
						// rearm for the next string
						act_q <= ACT_INIT;
					end
					default: begin
						act_q <= act_q;
					end
				endcase
			end
		end
	end

	// overflow only ever seen with a full pattern
	`WSM_ASSERT_IMP(a_ovf_full, clk, arst_n, ovf_q, len_q == LEN_MAX, "overflow with room left")

	// nothing reachable past the pattern end
	`WSM_ASSERT_IMP(a_act_in_range, clk, arst_n, 1'b1, (act_q >> len_q) <= ACT_INIT, "position past pattern end reachable")

	// an end-of-string item always rearms and raises the result
	`WSM_ASSERT_NXT(a_end_rearm, clk, arst_n, s1_go && (mode_s1 == MODE_END), (act_q == ACT_INIT) && out_valid_q, "end of string did not rearm")
endmodule

`default_nettype wire
